### hdl/llca_pkg.sv
// ----------------------------------------------------------------------------
// llca_pkg
// Shared types and constants for the Life-like automaton row stepper.
// ----------------------------------------------------------------------------
`default_nettype none

package llca_pkg;

  // Row and counter geometry
  localparam int MaxWidth    = 64;
  localparam int MaxHeight   = 4096;
  localparam int RowW        = 64;
  localparam int IdxW        = 12;
  localparam int HeightW     = 13;
  localparam int GridWidthW  = 7;
  localparam int MaskW       = 9;
  localparam int CfgDataW    = 13;
  localparam int OutDepth    = 4;
  localparam int OutPtrW     = 2;
  localparam int OutCntW     = 3;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BIRTH   = 2'd0,
    REG_SURVIVE = 2'd1,
    REG_WIDTH   = 2'd2,
    REG_HEIGHT  = 2'd3
  } cfg_reg_t;

  // Decoded configuration seen by the datapath
  typedef struct packed {
    logic [MaskW-1:0]   birth_mask;
    logic [MaskW-1:0]   survive_mask;
    logic [RowW-1:0]    width_mask;
    logic [HeightW-1:0] eff_height;
  } cfg_t;

  // One result row
  typedef struct packed {
    logic [RowW-1:0] next_row_cells;
    logic [IdxW-1:0] out_row_index;
    logic            frame_done;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/llca_if.sv
// ----------------------------------------------------------------------------
// llca channel interfaces
// Valid/ready channels for input rows, result rows and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface llca_in_if;
  import llca_pkg::*;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] row_cells;
  modport source (output valid, output row_cells, input ready);
  modport sink   (input valid, input row_cells, output ready);
endinterface

interface llca_out_if;
  import llca_pkg::*;
  logic            valid;
  logic            ready;
  logic [RowW-1:0] next_row_cells;
  logic [IdxW-1:0] out_row_index;
  logic            frame_done;
  modport source (output valid, output next_row_cells, output out_row_index,
                  output frame_done, input ready);
  modport sink   (input valid, input next_row_cells, input out_row_index,
                  input frame_done, output ready);
endinterface

interface llca_cfg_if;
  import llca_pkg::*;
  logic                valid;
  logic                ready;
  cfg_reg_t            index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/life_like_automaton_row_step.sv
// ----------------------------------------------------------------------------
// life_like_automaton_row_step
// One generation of a Life-like (B/S rule) automaton over a row stream.
//
// Rows of the current generation enter on row_in, top row first, one row
// per transaction. Each row yields the next-generation row of the row above
// it on row_out, tagged with its row number; the last row of a frame
// (grid_height rows) yields two transactions, the second with frame_done set.
// The first row of a frame yields nothing unless the height is one.
// Registers (birth_mask, survive_mask, grid_width, grid_height) are written
// over cfg, index 0..3; the user must do so only while no row is in flight,
// as the block itself does not enforce it. A result is offered once its input
// row has passed the input register and the neighbor-count logic into a
// 4-deep result queue. A row can be taken every cycle while the queue has room
// for two results; the queue drains one result per cycle while row_out is
// ready. A frame of H rows yields H results, the last row's two in order.
// When row_out stalls the queue fills; row_in.ready drops while a row waits in
// the input register with fewer than two queue slots free. Reset restores the
// default rule B3/S23, a 40x30 grid and an empty frame.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_row_step
  import llca_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  llca_in_if.sink    row_in,
  llca_out_if.source row_out,
  llca_cfg_if.sink   cfg
);

  cfg_t             cfg_q;
  logic [RowW-1:0]  above_row;
  logic [RowW-1:0]  middle_row;
  logic [IdxW-1:0]  rows_received;

  logic             s1_valid;
  logic [RowW-1:0]  s1_up;
  logic [RowW-1:0]  s1_mid;
  logic [RowW-1:0]  s1_down;
  logic [IdxW-1:0]  s1_idx;
  logic             s1_has_a;
  logic             s1_has_b;

  logic             in_acc;
  logic             last_row;
  logic [RowW-1:0]  row_m;
  logic             space2;
  logic             s1_drain;
  logic [RowW-1:0]  gen_a;
  logic [RowW-1:0]  gen_b;
  out_item_t        item_a;
  out_item_t        item_b;

  llca_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .cfg_out (cfg_q)
  );

  // Input handshake and last-row detect
  assign s1_drain     = s1_valid && space2;
  assign row_in.ready = !s1_valid || space2;
  assign in_acc       = row_in.valid && row_in.ready;
  assign row_m        = row_in.row_cells & cfg_q.width_mask;
  assign last_row     = ({1'b0, rows_received} + HeightW'(1)) >= cfg_q.eff_height;

  // Row window state
  always_ff @(posedge clk) begin
    if (rst) begin
      above_row     <= '0;
      middle_row    <= '0;
      rows_received <= '0;
    end else if (in_acc) begin
      if (last_row) begin
        above_row     <= '0;
        middle_row    <= '0;
        rows_received <= '0;
      end else begin
        above_row     <= middle_row & cfg_q.width_mask;
        middle_row    <= row_m;
        rows_received <= rows_received + IdxW'(1);
      end
    end
  end

  // Input register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_drain) begin
      s1_valid <= 1'b0;
    end
  end

  // Input register: payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_up    <= above_row & cfg_q.width_mask;
      s1_mid   <= middle_row & cfg_q.width_mask;
      s1_down  <= row_m;
      s1_idx   <= rows_received;
      s1_has_a <= (rows_received != '0);
      s1_has_b <= last_row;
    end
  end

  // Row above the incoming one
  llca_row_gen u_gen_a (
    .up       (s1_up),
    .mid      (s1_mid),
    .down     (s1_down),
    .cfg      (cfg_q),
    .next_row (gen_a)
  );

  // Incoming row itself, with dead rows below (last row only)
  llca_row_gen u_gen_b (
    .up       (s1_mid),
    .mid      (s1_down),
    .down     ('0),
    .cfg      (cfg_q),
    .next_row (gen_b)
  );

  always_comb begin
    item_a.next_row_cells = gen_a;
    item_a.out_row_index  = s1_idx - IdxW'(1);
    item_a.frame_done     = 1'b0;
    item_b.next_row_cells = gen_b;
    item_b.out_row_index  = s1_idx;
    item_b.frame_done     = 1'b1;
  end

  llca_out_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push_a  (s1_drain && s1_has_a),
    .item_a  (item_a),
    .push_b  (s1_drain && s1_has_b),
    .item_b  (item_b),
    .space2  (space2),
    .row_out (row_out)
  );

  // Checks
  a_load_s1: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> s1_valid)
    else $error("accepted row not held in input register");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !space2) |=> (s1_valid && $stable(s1_down) && $stable(s1_idx)))
    else $error("input register changed while blocked");

  a_first_row_no_a: assert property (@(posedge clk) disable iff (rst)
    (in_acc && rows_received == '0) |=> !s1_has_a)
    else $error("first row of frame produced an upper result");

endmodule

`default_nettype wire

### hdl/llca_cfg_regs.sv
// ----------------------------------------------------------------------------
// llca_cfg_regs
// Rule and geometry registers, with clamped width/height and the row mask.
// ----------------------------------------------------------------------------
`default_nettype none

module llca_cfg_regs
  import llca_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  llca_cfg_if.sink    cfg,
  output cfg_t        cfg_out
);

  logic [MaskW-1:0]      birth_mask;
  logic [MaskW-1:0]      survive_mask;
  logic [GridWidthW-1:0] grid_width;
  logic [HeightW-1:0]    grid_height;
  logic [GridWidthW-1:0] eff_width;
  logic [RowW-1:0]       wmask;

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      birth_mask   <= MaskW'(8);
      survive_mask <= MaskW'(12);
      grid_width   <= GridWidthW'(40);
      grid_height  <= HeightW'(30);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BIRTH:   birth_mask   <= cfg.data[MaskW-1:0];
        REG_SURVIVE: survive_mask <= cfg.data[MaskW-1:0];
        REG_WIDTH:   grid_width   <= cfg.data[GridWidthW-1:0];
        REG_HEIGHT:  grid_height  <= cfg.data[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to 1..MaxWidth and build the live-cell mask
  always_comb begin
    if (grid_width == '0) begin
      eff_width = GridWidthW'(1);
    end else if (grid_width > GridWidthW'(MaxWidth)) begin
      eff_width = GridWidthW'(MaxWidth);
    end else begin
      eff_width = grid_width;
    end
    for (int x = 0; x < RowW; x++) begin
      wmask[x] = (GridWidthW'(x) < eff_width);
    end
  end

  // Clamp height to 1..MaxHeight
  always_comb begin
    cfg_out.birth_mask   = birth_mask;
    cfg_out.survive_mask = survive_mask;
    cfg_out.width_mask   = wmask;
    if (grid_height == '0) begin
      cfg_out.eff_height = HeightW'(1);
    end else if (grid_height > HeightW'(MaxHeight)) begin
      cfg_out.eff_height = HeightW'(MaxHeight);
    end else begin
      cfg_out.eff_height = grid_height;
    end
  end

endmodule

`default_nettype wire

### hdl/llca_row_gen.sv
// ----------------------------------------------------------------------------
// llca_row_gen
// Next-generation row from three masked rows: per-column neighbor count
// and birth/survive rule lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module llca_row_gen
  import llca_pkg::*;
(
  input  wire logic [RowW-1:0]  up,
  input  wire logic [RowW-1:0]  mid,
  input  wire logic [RowW-1:0]  down,
  input  wire cfg_t             cfg,
  output logic      [RowW-1:0]  next_row
);

  logic [RowW+1:0] up_p;
  logic [RowW+1:0] mid_p;
  logic [RowW+1:0] down_p;

  // Pad a dead column on each side
  assign up_p   = {1'b0, up,   1'b0};
  assign mid_p  = {1'b0, mid,  1'b0};
  assign down_p = {1'b0, down, 1'b0};

  // Count the 8 neighbors of every column and apply the rule
  always_comb begin
    logic [3:0]       n;
    logic [MaskW-1:0] rule;
    for (int x = 0; x < RowW; x++) begin
      n = 4'(up_p[x]) + 4'(up_p[x+1]) + 4'(up_p[x+2])
        + 4'(mid_p[x]) + 4'(mid_p[x+2])
        + 4'(down_p[x]) + 4'(down_p[x+1]) + 4'(down_p[x+2]);
      rule = mid[x] ? cfg.survive_mask : cfg.birth_mask;
      next_row[x] = rule[n] & cfg.width_mask[x];
    end
  end

endmodule

`default_nettype wire

### hdl/llca_out_fifo.sv
// ----------------------------------------------------------------------------
// llca_out_fifo
// Small result queue; takes up to two rows per cycle, hands out one while row_out is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module llca_out_fifo
  import llca_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_a,
  input  wire out_item_t item_a,
  input  wire logic      push_b,
  input  wire out_item_t item_b,
  output logic           space2,
  llca_out_if.source     row_out
);

  out_item_t             mem [OutDepth];
  logic [OutPtrW-1:0]    wr_ptr;
  logic [OutPtrW-1:0]    rd_ptr;
  logic [OutCntW-1:0]    count;
  logic [OutPtrW-1:0]    b_ptr;
  logic                  pop;
  out_item_t             head;

  assign space2 = (count <= OutCntW'(OutDepth - 2));
  assign pop    = row_out.valid && row_out.ready;
  assign b_ptr  = wr_ptr + OutPtrW'(push_a);

  // Storage writes
  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wr_ptr] <= item_a;
    end
    if (push_b) begin
      mem[b_ptr] <= item_b;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OutPtrW'(push_a) + OutPtrW'(push_b);
      rd_ptr <= rd_ptr + OutPtrW'(pop);
      count  <= count + OutCntW'(push_a) + OutCntW'(push_b) - OutCntW'(pop);
    end
  end

  assign head                   = mem[rd_ptr];
  assign row_out.valid          = (count != '0);
  assign row_out.next_row_cells = head.next_row_cells;
  assign row_out.out_row_index  = head.out_row_index;
  assign row_out.frame_done     = head.frame_done;

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= OutCntW'(OutDepth))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    (push_a || push_b) |-> space2)
    else $error("push without room for two rows");

endmodule

`default_nettype wire

### tb/sv/llca_row_checker.sv
// ----------------------------------------------------------------------------
// llca_row_checker
// Watches the row, result and register channels of the Life-like row
// stepper. It keeps its own copy of the rule registers and of the two stored
// rows, works out the next-generation rows that each accepted row must yield,
// and compares every result transaction field by field with the oldest one.
// ----------------------------------------------------------------------------
module llca_row_checker
  import llca_pkg::*;
(
  input  logic clk,
  input  logic rst,
  llca_in_if   row_in,
  llca_out_if  row_out,
  llca_cfg_if  cfg,
  output int   mismatches,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the rule and geometry registers
  logic [MaskW-1:0]      birth_rule;
  logic [MaskW-1:0]      survive_rule;
  logic [GridWidthW-1:0] width_reg;
  logic [HeightW-1:0]    height_reg;

  // Frame state: the two rows held back and the row count so far
  logic [RowW-1:0] row_above;
  logic [RowW-1:0] row_mid;
  logic [IdxW-1:0] rows_seen;

  out_item_t expected_rows[$];

  // Live columns; width zero acts as one, anything wider than a row as full
  function automatic logic [RowW-1:0] row_mask();
    int w;
    w = width_reg;
    if (w < 1) w = 1;
    if (w > MaxWidth) w = MaxWidth;
    return (w >= RowW) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic int frame_height();
    int h;
    h = height_reg;
    if (h < 1) h = 1;
    if (h > MaxHeight) h = MaxHeight;
    return h;
  endfunction

  // Next generation of mid; columns outside the grid count as dead
  function automatic logic [RowW-1:0] next_generation_row(
    input logic [RowW-1:0] up,
    input logic [RowW-1:0] mid,
    input logic [RowW-1:0] down
  );
    logic [RowW-1:0]   m;
    logic [RowW-1:0]   res;
    logic [RowW+1:0]   u;
    logic [RowW+1:0]   c;
    logic [RowW+1:0]   d;
    logic [MaskW-1:0]  rule;
    int                n;
    m = row_mask();
    // pad one dead column on each side: padded bit x+1 is column x
    u = {1'b0, up & m, 1'b0};
    c = {1'b0, mid & m, 1'b0};
    d = {1'b0, down & m, 1'b0};
    res = '0;
    for (int x = 0; x < RowW; x++) begin
      n = u[x] + u[x+1] + u[x+2] + c[x] + c[x+2] + d[x] + d[x+1] + d[x+2];
      rule = c[x+1] ? survive_rule : birth_rule;
      res[x] = rule[n];
    end
    return res & m;
  endfunction

  function automatic void add_expected(input logic [RowW-1:0] cells, input int idx,
                                       input logic done);
    out_item_t e;
    e.next_row_cells = cells;
    e.out_row_index  = IdxW'(idx);
    e.frame_done     = done;
    expected_rows.push_back(e);
  endfunction

  function automatic void clear_frame();
    row_above = '0;
    row_mid   = '0;
    rows_seen = '0;
  endfunction

  always @(posedge clk) begin
    out_item_t       want;
    logic [RowW-1:0] m;
    logic [RowW-1:0] cells;
    int              r;
    logic            last;
    if (rst) begin
      birth_rule   = 9'd8;
      survive_rule = 9'd12;
      width_reg    = 7'd40;
      height_reg   = 13'd30;
      clear_frame();
      expected_rows.delete();
      mismatches   = 0;
    end else begin
      // Result transaction: compare with the oldest expected row
      if (row_out.valid && row_out.ready) begin
        if (expected_rows.size() == 0) begin
          $display("%0t: result with none expected: cells %h row %0d done %b", $time,
                   row_out.next_row_cells, row_out.out_row_index, row_out.frame_done);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          if (row_out.next_row_cells !== want.next_row_cells) begin
            $display("%0t: next_row_cells expected %h actual %h", $time,
                     want.next_row_cells, row_out.next_row_cells);
            mismatches++;
          end
          if (row_out.out_row_index !== want.out_row_index) begin
            $display("%0t: out_row_index expected %0d actual %0d", $time,
                     want.out_row_index, row_out.out_row_index);
            mismatches++;
          end
          if (row_out.frame_done !== want.frame_done) begin
            $display("%0t: frame_done expected %b actual %b", $time,
                     want.frame_done, row_out.frame_done);
            mismatches++;
          end
        end
      end

      // Row transaction: emit the row above (none for a frame's first row), and on the last row flush it too
      if (row_in.valid && row_in.ready) begin
        m     = row_mask();
        cells = row_in.row_cells & m;
        r     = rows_seen;
        last  = (r + 1) >= frame_height();
        if (r == 0) begin
          if (last) begin
            add_expected(next_generation_row('0, cells, '0), 0, 1'b1);
            clear_frame();
          end else begin
            row_above = '0;
            row_mid   = cells;
            rows_seen = IdxW'(1);
          end
        end else begin
          add_expected(next_generation_row(row_above, row_mid, cells), r - 1, 1'b0);
          if (last) begin
            add_expected(next_generation_row(row_mid, cells, '0), r, 1'b1);
            clear_frame();
          end else begin
            row_above = row_mid & m;
            row_mid   = cells;
            rows_seen = IdxW'(r + 1);
          end
        end
      end

      // Register write
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BIRTH:   birth_rule   = cfg.data[MaskW-1:0];
          REG_SURVIVE: survive_rule = cfg.data[MaskW-1:0];
          REG_WIDTH:   width_reg    = cfg.data[GridWidthW-1:0];
          REG_HEIGHT:  height_reg   = cfg.data[HeightW-1:0];
          default: ;
        endcase
      end
    end
    pending = expected_rows.size();
  end

endmodule

### tb/sv/tb_life_like_automaton_row_step.sv
// ----------------------------------------------------------------------------
// tb_life_like_automaton_row_step
// Streams row frames through the Life-like row stepper under many rules and
// grid sizes: a directed set of edge cases (height one and zero, width zero
// and oversized, junk beyond the width, height and width changed mid-frame),
// random phases of mostly whole frames, and a long frame under the saturated
// height register. Both channels idle at random; llca_row_checker does the
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_life_like_automaton_row_step;
  import llca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 200000;
  localparam int RandomRows  = 1450;
  localparam int DrainCycles = 4;
  localparam int LongFrame   = 48;

  logic clk;
  logic rst;
  bit   steady;
  int   mismatches;
  int   pending;
  int   cycles;

  llca_in_if  row_in_ch ();
  llca_out_if row_out_ch ();
  llca_cfg_if cfg_ch ();

  life_like_automaton_row_step DUT (
    .clk     (clk),
    .rst     (rst),
    .row_in  (row_in_ch),
    .row_out (row_out_ch),
    .cfg     (cfg_ch)
  );

  llca_row_checker row_check (
    .clk        (clk),
    .rst        (rst),
    .row_in     (row_in_ch),
    .row_out    (row_out_ch),
    .cfg        (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #4 clk = ~clk;

  // Result side back-pressure, off during steady stretches
  always @(negedge clk) begin
    row_out_ch.ready <= steady || ($urandom_range(99) >= 18);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("life_like_automaton_row_step: mismatch");
      $finish;
    end
  end

  // Writes all four registers back to back; unused data bits get noise
  task automatic write_regs(input logic [MaskW-1:0] born, input logic [MaskW-1:0] kept,
                            input logic [GridWidthW-1:0] cols,
                            input logic [HeightW-1:0] rows);
    cfg_reg_t            regs [4];
    logic [CfgDataW-1:0] vals [4];
    regs    = '{REG_BIRTH, REG_SURVIVE, REG_WIDTH, REG_HEIGHT};
    vals[0] = {4'($urandom), born};
    vals[1] = {4'($urandom), kept};
    vals[2] = {6'($urandom), cols};
    vals[3] = rows;
    for (int i = 0; i < 4; i++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= regs[i];
      cfg_ch.data  <= vals[i];
      do @(posedge clk); while (!cfg_ch.ready);
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // One row transaction, with random idle cycles ahead of it
  task automatic send_row(input logic [RowW-1:0] cells);
    while (!steady && $urandom_range(99) < 18) begin
      row_in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    row_in_ch.valid     <= 1'b1;
    row_in_ch.row_cells <= cells;
    do @(posedge clk); while (!row_in_ch.ready);
    @(negedge clk);
  endtask

  // Hold the sender until every expected row is back, then let the pipe empty
  task automatic wait_for_results();
    row_in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Rows of varied density
  function automatic logic [RowW-1:0] random_row();
    logic [RowW-1:0] a;
    logic [RowW-1:0] b;
    logic [RowW-1:0] c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(3))
      0:       return a;
      1:       return a & b;
      2:       return a | b;
      default: return a & b & c;
    endcase
  endfunction

  initial begin
    logic [MaskW-1:0]      born;
    logic [MaskW-1:0]      kept;
    logic [GridWidthW-1:0] cols;
    logic [HeightW-1:0]    rows;
    int                    h;
    int                    span;
    int                    phase;
    int                    random_rows;

    clk                 = 1'b0;
    rst                 = 1'b1;
    steady              = 1'b0;
    row_in_ch.valid     = 1'b0;
    row_in_ch.row_cells = '0;
    row_out_ch.ready    = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = REG_BIRTH;
    cfg_ch.data         = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Height one: every row is its own frame
    write_regs(9'd8, 9'd12, 7'd64, 13'd1);
    send_row('1);
    send_row('0);
    send_row(64'h8000_0000_0000_0001);
    wait_for_results();

    // Width zero acts as one column; all-birth, no-survive rule
    write_regs(9'h1FF, 9'h000, 7'd0, 13'd3);
    repeat (3) send_row('1);
    wait_for_results();

    // Oversized width and height zero
    write_regs(9'h000, 9'h1FF, 7'd127, 13'd0);
    send_row(64'hA5A5_5A5A_0F0F_F0F0);
    send_row('1);
    wait_for_results();

    // Glider on a five-column grid with junk beyond the width
    write_regs(9'd8, 9'd12, 7'd5, 13'd4);
    send_row(64'hFFFF_FFFF_FFFF_FFE2);
    send_row(64'hFFFF_FFFF_FFFF_FFE4);
    send_row(64'hFFFF_FFFF_FFFF_FFE7);
    send_row(64'hFFFF_FFFF_FFFF_FFE0);
    wait_for_results();

    // Height lowered and width narrowed part way through a frame
    write_regs(9'd8, 9'd12, 7'd64, 13'd10);
    repeat (3) send_row(random_row());
    wait_for_results();
    write_regs(9'd8, 9'd12, 7'd16, 13'd2);
    send_row(random_row());
    wait_for_results();

    // Two-row frame
    write_regs(9'd2, 9'd0, 7'd63, 13'd2);
    send_row(random_row());
    send_row(random_row());
    wait_for_results();

    // Random phases, mostly whole frames; a partial tail leaves the next
    // register change landing mid-frame
    phase       = 0;
    random_rows = 0;
    while (random_rows < RandomRows) begin
      if ($urandom_range(4) == 0) begin
        born = 9'd8;
        kept = 9'd12;
      end else begin
        born = 9'($urandom);
        kept = 9'($urandom);
      end
      case ($urandom_range(9))
        0:       cols = 7'd1;
        1:       cols = 7'd64;
        2:       cols = 7'd0;
        3:       cols = 7'd127;
        4:       cols = 7'($urandom_range(65, 126));
        default: cols = 7'($urandom_range(2, 63));
      endcase
      case ($urandom_range(7))
        0:       rows = 13'd1;
        1:       rows = 13'd0;
        2:       rows = 13'd2;
        3:       rows = 13'($urandom_range(20, 60));
        default: rows = 13'($urandom_range(3, 12));
      endcase
      write_regs(born, kept, cols, rows);
      steady <= (phase == 2);
      h    = (rows == 0) ? 1 : int'(rows);
      span = h * $urandom_range(1, 4);
      if ($urandom_range(3) == 0) span += $urandom_range(1, h);
      // the idle-free phase runs long
      if (phase == 2) span += 200;
      repeat (span) send_row(random_row());
      wait_for_results();
      random_rows += span;
      phase++;
    end
    steady <= 1'b0;

    // A height-one row closes whatever frame is open, then a long frame with
    // the height register saturated, itself closed by a height-one row
    write_regs(9'd8, 9'd12, 7'd64, 13'd1);
    send_row(random_row());
    wait_for_results();
    write_regs(9'($urandom), 9'($urandom), 7'd64, 13'd8191);
    repeat (LongFrame) send_row(random_row());
    wait_for_results();
    write_regs(9'd8, 9'd12, 7'd64, 13'd1);
    send_row(random_row());
    wait_for_results();

    if (mismatches == 0 && pending == 0) begin
      $display("life_like_automaton_row_step: match");
    end else begin
      $display("life_like_automaton_row_step: mismatch");
    end
    $finish;
  end

endmodule
